// ===== sv/sed_pkg.sv =====
package sed_pkg;

	localparam int unsigned MaxRes = 3;

	// escape state codes
	localparam logic [1:0] ModePlain = 2'd0;
	localparam logic [1:0] ModeEsc   = 2'd1;
	localparam logic [1:0] ModeOct1  = 2'd2;
	localparam logic [1:0] ModeOct2  = 2'd3;

	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChLowB      = 8'h62;
	localparam logic [7:0] ChLowT      = 8'h74;
	localparam logic [7:0] ChLowN      = 8'h6E;
	localparam logic [7:0] ChLowR      = 8'h72;
	localparam logic [4:0] ChOctHigh   = 5'b00110;

	localparam logic [7:0] CodeBackspace = 8'd8;
	localparam logic [7:0] CodeTab       = 8'd9;
	localparam logic [7:0] CodeNewline   = 8'd10;
	localparam logic [7:0] CodeReturn    = 8'd13;
	localparam logic [7:0] CodeNul       = 8'd0;

	typedef struct packed {
		logic [1:0]                count;
		logic [MaxRes-1:0][7:0]    data;
		logic [MaxRes-1:0]         term;
	} sed_res_t;

endpackage

// ===== sv/string_escape_decoder_core.sv =====
// channel   dir  tdata           tlast          tuser
// s_axis    in   in_byte[7:0]    end_of_input   -
// m_axis    out  out_byte[7:0]   last_of_run    is_terminator
//
// one input byte per cycle while the result buffer is free; a taken byte is
// registered, then decoded into the buffer; a byte with two or three results
// holds s_axis as the three-entry buffer drains, one result per ready cycle
// arst_n clears the escape state and empties both stages
// s_axis_tready depends on m_axis_tready through the result buffer
module string_escape_decoder_core import sed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // in_byte
	input  logic       s_axis_tlast,   // end_of_input
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // out_byte
	output logic       m_axis_tlast,   // last_of_run
	output logic       m_axis_tuser    // is_terminator
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       buf_free;
	logic       xfer;
	sed_res_t   res;

	assign xfer          = valid_s1 && buf_free;
	assign s_axis_tready = !valid_s1 || xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	sed_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (xfer),
		.in_byte      (byte_s1),
		.end_of_input (last_s1),
		.res          (res)
	);

	sed_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (xfer),
		.res    (res),
		.free   (buf_free),
		.tvalid (m_axis_tvalid),
		.tready (m_axis_tready),
		.tdata  (m_axis_tdata),
		.tlast  (m_axis_tlast),
		.term   (m_axis_tuser)
	);

endmodule

// ===== sv/sed_decode.sv =====
module sed_decode import sed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	output sed_res_t   res
);

	logic [1:0] mode_q;
	logic [7:0] oval_q;
	logic [1:0] nmode;
	logic [7:0] noval;
	logic       is_oct;
	logic [7:0] oct_acc;

	assign is_oct  = (in_byte[7:3] == ChOctHigh);
	assign oct_acc = {oval_q[4:0], in_byte[2:0]};

	always_comb begin
		res   = '0;
		nmode = mode_q;
		noval = oval_q;
		unique case (mode_q)
			ModePlain: begin
				if (in_byte == ChBackslash) begin
					nmode = ModeEsc;
				end else begin
					res.data[0] = in_byte;
					res.count   = 2'd1;
				end
			end
			ModeEsc: begin
				nmode     = ModePlain;
				res.count = 2'd1;
				priority if (in_byte == ChLowB) begin
					res.data[0] = CodeBackspace;
				end else if (in_byte == ChLowT) begin
					res.data[0] = CodeTab;
				end else if (in_byte == ChLowN) begin
					res.data[0] = CodeNewline;
				end else if (in_byte == ChLowR) begin
					res.data[0] = CodeReturn;
				end else if (is_oct) begin
					res.count = 2'd0;
					noval     = {5'd0, in_byte[2:0]};
					nmode     = ModeOct1;
				end else begin
					res.data[0] = in_byte;
				end
			end
			default: begin
				priority if (is_oct) begin
					noval = oct_acc;
					if (mode_q == ModeOct1) begin
						nmode = ModeOct2;
					end else begin
						res.data[0] = oct_acc;
						res.count   = 2'd1;
						nmode       = ModePlain;
					end
				end else if (in_byte == ChBackslash) begin
					res.data[0] = oval_q;
					res.count   = 2'd1;
					nmode       = ModeEsc;
				end else begin
					res.data[0] = oval_q;
					res.data[1] = in_byte;
					res.count   = 2'd2;
					nmode       = ModePlain;
				end
			end
		endcase

		if (end_of_input) begin
			// flush pending octal value, then the terminator
			if (nmode == ModeOct1 || nmode == ModeOct2) begin
				res.data[res.count] = noval;
				res.count           = res.count + 2'd1;
			end
			res.data[res.count] = CodeNul;
			res.term[res.count] = 1'b1;
			res.count           = res.count + 2'd1;
			nmode               = ModePlain;
			noval               = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ModePlain;
			oval_q <= '0;
		end else if (en) begin
			mode_q <= nmode;
			oval_q <= noval;
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		en && end_of_input |=> mode_q == ModePlain && oval_q == '0)
		else $error("state not cleared after end of string");

	a_oct_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == ModeOct1 |-> oval_q[7:3] == 5'd0)
		else $error("first octal digit wider than three bits");

endmodule

// ===== sv/sed_outbuf.sv =====
module sed_outbuf import sed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  sed_res_t   res,
	output logic       free,
	output logic       tvalid,
	input  logic       tready,
	output logic [7:0] tdata,
	output logic       tlast,
	output logic       term
);

	logic [MaxRes-1:0][7:0] data_q;
	logic [MaxRes-1:0]      term_q;
	logic [1:0]             cnt_q;
	logic [1:0]             ptr_q;
	logic                   fire;

	assign tvalid = (cnt_q != 2'd0);
	assign fire   = tvalid && tready;
	assign free   = (cnt_q == 2'd0) || (cnt_q == 2'd1 && tready);
	assign tlast  = (cnt_q == 2'd1);

	always_comb begin
		unique case (ptr_q)
			2'd0:    begin tdata = data_q[0]; term = term_q[0]; end
			2'd1:    begin tdata = data_q[1]; term = term_q[1]; end
			default: begin tdata = data_q[2]; term = term_q[2]; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res.data;
			term_q <= res.term;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
		end else if (load) begin
			cnt_q <= res.count;
			ptr_q <= '0;
		end else if (fire) begin
			cnt_q <= cnt_q - 2'd1;
			ptr_q <= ptr_q + 2'd1;
		end
	end

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> cnt_q == $past(res.count) && ptr_q == 2'd0)
		else $error("result buffer count wrong after load");

	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		tvalid && term |-> tlast && tdata == CodeNul)
		else $error("terminator not last or not zero");

endmodule
